// ===== design/cse_pkg.sv =====
`timescale 1ns / 1ps

package cse_pkg;

  // Default build parameters
  localparam int unsigned DefMaxTerms = 16;
  localparam int unsigned DefFracBits = 24;

  // Fixed field widths
  localparam int unsigned ValW   = 32;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned TermsW = 5;

  // APB register map
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned PdataW  = 32;
  localparam logic [1:0]  RegLow   = 2'd0;
  localparam logic [1:0]  RegHigh  = 2'd1;
  localparam logic [1:0]  RegTerms = 2'd2;

  // Reset values of the registers
  localparam logic signed [ValW-1:0] ResetLow   = 32'sd0;
  localparam logic signed [ValW-1:0] ResetHigh  = 32'sd16777216;
  localparam logic [TermsW-1:0]      ResetTerms = 5'd16;

  // Operation codes of an input item
  typedef enum logic {
    OpLoad = 1'b0,
    OpEval = 1'b1
  } op_e;

endpackage

// ===== design/cse_in_if.sv =====
`timescale 1ns / 1ps

interface cse_in_if;
  import cse_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [IdxW-1:0]        coef_index;
  logic signed [ValW-1:0] coef_value;
  logic signed [ValW-1:0] x_value;

  modport source (output valid, operation, coef_index, coef_value, x_value, input ready);
  modport sink (input valid, operation, coef_index, coef_value, x_value, output ready);
endinterface

// ===== design/cse_out_if.sv =====
`timescale 1ns / 1ps

interface cse_out_if;
  import cse_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] series_value;
  logic                   range_error;
  logic                   saturated;

  modport source (output valid, series_value, range_error, saturated, input ready);
  modport sink (input valid, series_value, range_error, saturated, output ready);
endinterface

// ===== design/chebyshev_series_eval_top.sv =====
// Load item: accepted while idle, gives no result.
// Evaluate item: a restoring divide and a sign fix, then per used term a multiply on the
// one shared multiplier and an add with saturation, then the output stage; an out-of-range
// x goes straight to the output stage.
// One item is worked on at a time; the coefficient store is one memory read per term.
// Reset (rst_ni low, asynchronous) clears control and the APB registers; the store is not cleared.
`timescale 1ns / 1ps

module chebyshev_series_eval_top #(
  parameter int unsigned MAX_TERMS = cse_pkg::DefMaxTerms,
  parameter int unsigned FRAC_BITS = cse_pkg::DefFracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cse_in_if.sink                        in_i,
  cse_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cse_pkg::PaddrW-1:0]    paddr,
  input  logic [cse_pkg::PdataW-1:0]    pwdata,
  output logic [cse_pkg::PdataW-1:0]    prdata,
  output logic                          pready
);
  import cse_pkg::*;

  localparam int unsigned IW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned QW   = FRAC_BITS + 1;
  localparam int unsigned YW   = FRAC_BITS + 2;
  localparam int unsigned PW   = YW + ValW;
  localparam int unsigned DCW  = $clog2(FRAC_BITS + 1);
  localparam int unsigned SW   = 36;
  localparam logic [IW-1:0]  LastIdx = IW'(MAX_TERMS - 1);
  localparam logic [DCW-1:0] DivLast = DCW'(FRAC_BITS);
  localparam logic signed [PW:0]  RndK = (PW + 1)'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SatMax = SW'(32'sh7fff_ffff);
  localparam logic signed [SW-1:0] SatMin = -SW'(64'sh8000_0000);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SGN  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  // Configuration registers
  logic signed [ValW-1:0] low_q, high_q;
  logic [TermsW-1:0]      terms_q;
  logic                   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q   <= ResetLow;
      high_q  <= ResetHigh;
      terms_q <= ResetTerms;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegLow:   low_q   <= $signed(pwdata);
        RegHigh:  high_q  <= $signed(pwdata);
        RegTerms: terms_q <= pwdata[TermsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegLow:   prdata = low_q;
      RegHigh:  prdata = high_q;
      RegTerms: prdata = {{(PdataW - TermsW){1'b0}}, terms_q};
      default:  prdata = '0;
    endcase
  end

  // Input handshake
  logic in_acc, is_load, is_eval;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_load    = in_acc && (in_i.operation == OpLoad);
  assign is_eval    = in_acc && (in_i.operation == OpEval);

  // Coefficient store, registered read
  logic signed [ValW-1:0] mem_q [MAX_TERMS];
  logic signed [ValW-1:0] coef_q;
  logic [IW-1:0]          j_q, j_d;

  always_ff @(posedge clk_i) begin
    if (is_load && (32'(in_i.coef_index) < MAX_TERMS)) begin
      mem_q[IW'(in_i.coef_index)] <= in_i.coef_value;
    end
    coef_q <= mem_q[j_q];
  end

  // Range check and interval mapping set-up
  logic                   range_err;
  logic signed [34:0]     num_w;
  logic [32:0]            den_w;
  logic [32:0]            mag_w;
  logic [IW-1:0]          top_idx;

  assign range_err = (high_q <= low_q) || (in_i.x_value < low_q) || (in_i.x_value > high_q);
  assign num_w = (35'(in_i.x_value) <<< 1) - 35'(low_q) - 35'(high_q);
  assign den_w = 33'(high_q) - 33'(low_q);
  assign mag_w = num_w[34] ? 33'(-num_w) : num_w[32:0];

  // Clamp the term count to [1, MAX_TERMS], as the highest index used
  always_comb begin
    if (terms_q == '0) begin
      top_idx = '0;
    end else if (32'(terms_q) > MAX_TERMS) begin
      top_idx = LastIdx;
    end else begin
      top_idx = IW'(terms_q - TermsW'(1));
    end
  end

  // Restoring divider: one quotient bit a cycle
  logic [32:0]    rem_q, rem_d, den_q;
  logic [QW-1:0]  quo_q, quo_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic           neg_q;
  logic [33:0]    trial;
  logic           fits;

  assign trial = (dcnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign fits  = (trial >= {1'b0, den_q});

  // Shared multiplier and accumulate path
  logic signed [YW-1:0]   y_q;
  logic signed [ValW-1:0] d_q, dd_q, d_d;
  logic signed [PW-1:0]   prod_q, prod_w;
  logic signed [PW:0]     dbl_w, rnd_w;
  logic signed [SW-1:0]   sum_w;
  logic signed [ValW-1:0] cadd_w;
  logic                   last_step, clip_w;

  assign prod_w    = y_q * d_q;
  assign last_step = (j_q == '0);
  assign dbl_w     = last_step ? {prod_q[PW-1], prod_q} : {prod_q, 1'b0};
  assign rnd_w     = (dbl_w + RndK) >>> FRAC_BITS;
  assign cadd_w    = last_step ? (coef_q >>> 1) : coef_q;
  assign sum_w     = $signed(rnd_w[SW-1:0]) - SW'(dd_q) + SW'(cadd_w);

  // Saturate to the 32-bit range
  always_comb begin
    clip_w = 1'b1;
    if (sum_w > SatMax) begin
      d_d = 32'sh7fff_ffff;
    end else if (sum_w < SatMin) begin
      d_d = 32'sh8000_0000;
    end else begin
      d_d    = sum_w[ValW-1:0];
      clip_w = 1'b0;
    end
  end

  // Result and output registers
  logic signed [ValW-1:0] res_q;
  logic                   err_q, clip_q;
  logic                   ov_q;
  logic signed [ValW-1:0] oval_q;
  logic                   oerr_q, osat_q;
  logic                   out_free;

  assign out_free            = !ov_q || out_o.ready;
  assign out_o.valid        = ov_q;
  assign out_o.series_value = oval_q;
  assign out_o.range_error  = oerr_q;
  assign out_o.saturated    = osat_q;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dcnt_d  = dcnt_q;
    j_d     = j_q;
    unique case (state_q)
      ST_IDLE: begin
        if (is_eval) begin
          rem_d  = mag_w;
          dcnt_d = '0;
          state_d = range_err ? ST_OUT : ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = fits ? 33'(trial - {1'b0, den_q}) : trial[32:0];
        quo_d  = {quo_q[QW-2:0], fits};
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DivLast) begin
          state_d = ST_SGN;
        end
      end
      ST_SGN: begin
        j_d     = top_idx;
        state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        if (last_step) begin
          state_d = ST_OUT;
        end else begin
          j_d     = j_q - IW'(1);
          state_d = ST_MUL;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dcnt_q  <= '0;
      j_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      dcnt_q  <= dcnt_d;
      j_q     <= j_d;
      if (state_q == ST_OUT && out_free) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    unique case (state_q)
      ST_IDLE: begin
        if (is_eval) begin
          den_q  <= den_w;
          neg_q  <= num_w[34];
          err_q  <= range_err;
          res_q  <= '0;
          clip_q <= 1'b0;
        end
      end
      ST_SGN: begin
        y_q  <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
        d_q  <= '0;
        dd_q <= '0;
      end
      ST_MUL: prod_q <= prod_w;
      ST_ACC: begin
        clip_q <= clip_q | clip_w;
        if (last_step) begin
          res_q <= d_d;
        end else begin
          d_q  <= d_d;
          dd_q <= d_q;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          oval_q <= res_q;
          oerr_q <= err_q;
          osat_q <= clip_q;
        end
      end
      default: ;
    endcase
  end

  // Checks
  ap_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && oerr_q |-> (oval_q == '0) && !osat_q)
    else $error("range error result not cleared");

  ap_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && (dcnt_q != '0) |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  ap_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SGN) |-> (quo_q <= (QW'(1) << FRAC_BITS)))
    else $error("mapped argument exceeds one");

  ap_load_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_load |=> (state_q == ST_IDLE))
    else $error("load item started an evaluation");

  ap_acc_follows_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |=> (state_q == ST_ACC) && (j_q == $past(j_q)))
    else $error("multiply not followed by accumulate");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import cse_pkg::*;

  localparam int unsigned MaxTerms = DefMaxTerms;
  localparam int unsigned FracBits = DefFracBits;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned PhaseItems = 175;
  localparam int unsigned Phases = 8;
  localparam logic signed [ValW-1:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [ValW-1:0] ValMin = 32'sh8000_0000;
  localparam logic signed [ValW-1:0] One = 32'sh0100_0000;
  localparam longint SatHi = 64'sd2147483647;
  localparam longint SatLo = -64'sd2147483648;

  typedef struct packed {
    op_e                    operation;
    logic [IdxW-1:0]        coef_index;
    logic signed [ValW-1:0] coef_value;
    logic signed [ValW-1:0] x_value;
  } cse_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] series_value;
    logic                   range_error;
    logic                   saturated;
  } series_res_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic pready;

  cse_in_if  in_if ();
  cse_out_if out_if ();

  chebyshev_series_eval_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Mirror of the block's registers and coefficient store
  logic signed [ValW-1:0] span_lo = ResetLow;
  logic signed [ValW-1:0] span_hi = ResetHigh;
  logic [TermsW-1:0]      term_count = ResetTerms;
  logic signed [ValW-1:0] coef_mirror [MaxTerms];

  series_res_t expected_series [$];

  int unsigned err_count = 0;
  int unsigned n_loads = 0;
  int unsigned n_evals = 0;
  int unsigned n_range_errs = 0;
  int unsigned n_clipped = 0;
  int unsigned n_settings = 0;

  // Traffic shaping shared by the tests and the result sink
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int unsigned hold_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #(10_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Product of two Q values, rounded half up
  function automatic longint mul_q(input longint u, input longint v);
    return (u * v + (longint'(1) <<< (FracBits - 1))) >>> FracBits;
  endfunction

  function automatic longint sat_q(input longint v);
    if (v > SatHi) return SatHi;
    if (v < SatLo) return SatLo;
    return v;
  endfunction

  // Clenshaw evaluation at x under the mirrored settings
  function automatic series_res_t predict_series(input logic signed [ValW-1:0] x);
    series_res_t r;
    longint a, b, xv, num, y, d, dd, prev, raw;
    longint unsigned mag;
    int n, j;
    bit clip;
    a = span_lo;
    b = span_hi;
    xv = x;
    r = '0;
    clip = 1'b0;
    d = 0;
    dd = 0;
    if (b <= a || xv < a || xv > b) begin
      r.range_error = 1'b1;
      return r;
    end
    // Map x onto [-1, 1], quotient truncated towards zero
    num = 2 * xv - a - b;
    mag = (num < 0) ? -num : num;
    mag = (mag << FracBits) / longint'(b - a);
    y = (num < 0) ? -longint'(mag) : longint'(mag);
    n = term_count;
    if (n < 1) n = 1;
    if (n > MaxTerms) n = MaxTerms;
    for (j = n - 1; j >= 1; j--) begin
      prev = d;
      raw = mul_q(2 * y, d) - dd + coef_mirror[j];
      d = sat_q(raw);
      if (d != raw) clip = 1'b1;
      dd = prev;
    end
    raw = mul_q(y, d) - dd + (coef_mirror[0] >>> 1);
    d = sat_q(raw);
    if (d != raw) clip = 1'b1;
    r.series_value = d[ValW-1:0];
    r.saturated = clip;
    return r;
  endfunction

  function automatic logic signed [ValW-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1) ? ValMax : ValMin;
      default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    endcase
  endfunction

  // Mostly inside the interval, with its ends, just outside and anywhere
  function automatic logic signed [ValW-1:0] rand_x();
    longint lo, hi, off;
    lo = span_lo;
    hi = span_hi;
    off = {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF;
    if (hi <= lo) return $urandom;
    case ($urandom_range(0, 9))
      0: return ValW'(lo);
      1: return ValW'(hi);
      2: return ValW'(lo - 1);
      3: return ValW'(hi + 1);
      4: return $urandom;
      default: return ValW'(lo + off % (hi - lo + 1));
    endcase
  endfunction

  function automatic cse_item_t load_item(input int idx, input logic signed [ValW-1:0] val);
    cse_item_t it;
    it.operation = OpLoad;
    it.coef_index = IdxW'(idx);
    it.coef_value = val;
    it.x_value = $urandom;
    return it;
  endfunction

  function automatic cse_item_t eval_item(input logic signed [ValW-1:0] x);
    cse_item_t it;
    it.operation = OpEval;
    it.coef_index = IdxW'($urandom_range(0, MaxTerms - 1));
    it.coef_value = $urandom;
    it.x_value = x;
    return it;
  endfunction

  function automatic cse_item_t rand_item();
    cse_item_t it;
    it.operation = ($urandom_range(0, 9) < 3) ? OpLoad : OpEval;
    it.coef_index = IdxW'($urandom_range(0, MaxTerms - 1));
    it.coef_value = rand_coef();
    it.x_value = rand_x();
    return it;
  endfunction

  // Offer one item, after a random gap unless tx_steady is set; record what it should cause once taken
  task automatic offer_item(input cse_item_t it);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.operation = it.operation;
    in_if.coef_index = it.coef_index;
    in_if.coef_value = it.coef_value;
    in_if.x_value = it.x_value;
    in_if.valid = 1'b1;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    if (it.operation == OpLoad) begin
      coef_mirror[it.coef_index] = it.coef_value;
      n_loads++;
    end else begin
      expected_series.push_back(predict_series(it.x_value));
      n_evals++;
    end
  endtask

  // Drop valid, wait for every pending result, then let the block settle
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (expected_series.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PdataW-1:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      RegLow:   span_lo = val;
      RegHigh:  span_hi = val;
      RegTerms: term_count = val[TermsW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic signed [ValW-1:0] lo, input logic signed [ValW-1:0] hi,
                            input logic [TermsW-1:0] terms);
    wait_drained();
    write_reg(RegLow, lo);
    write_reg(RegHigh, hi);
    write_reg(RegTerms, {{(PdataW - TermsW){1'b0}}, terms});
    n_settings++;
  endtask

  task automatic pick_interval(output logic signed [ValW-1:0] lo,
                               output logic signed [ValW-1:0] hi);
    logic signed [ValW-1:0] t;
    if ($urandom_range(0, 1)) begin
      lo = $urandom;
      hi = $urandom;
    end else begin
      lo = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      hi = lo + $urandom_range(1, 32'h0400_0000);
    end
    if (lo > hi) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    if (lo == hi) begin
      if (lo == ValMax) lo = lo - 1;
      else hi = hi + 1;
    end
  endtask

  // Fill the store with extreme and small coefficients and evaluate in and around the reset interval
  task automatic test_reset_defaults();
    logic signed [ValW-1:0] seed_coefs [MaxTerms];
    int i;
    seed_coefs = '{-32'sd3, One, ValMax, ValMin, -One, 32'sd0, 32'sd1, -32'sd1,
                   32'sh0080_0000, -32'sh0040_0000, 32'sh5555_5555, 32'shAAAA_AAAA,
                   32'sh0300_0000, -32'sh0500_0000, 32'sh0010_0000, 32'sh0000_FFFF};
    for (i = 0; i < MaxTerms; i++) offer_item(load_item(i, seed_coefs[i]));
    offer_item(eval_item(32'sd0));
    offer_item(eval_item(One));
    offer_item(eval_item(32'sh0080_0000));
    offer_item(eval_item(-32'sd1));
    offer_item(eval_item(One + 1));
    offer_item(eval_item(ValMin));
    offer_item(eval_item(ValMax));
  endtask

  // Term counts beyond both ends, a single term, empty and reversed intervals
  task automatic test_corner_settings();
    set_config(32'sd0, One, 5'd0);
    offer_item(eval_item(32'sh0080_0000));
    set_config(32'sd0, One, 5'd31);
    offer_item(eval_item(32'sh0040_0000));
    set_config(-One, One, 5'd1);
    offer_item(eval_item(32'sd0));
    offer_item(eval_item(-One));
    set_config(One, One, 5'd16);
    offer_item(eval_item(One));
    set_config(One, 32'sd0, 5'd16);
    offer_item(eval_item(32'sh0080_0000));
    offer_item(eval_item(32'sd0));
  endtask

  // Random traffic under a sequence of register settings
  task automatic test_random_settings();
    logic signed [ValW-1:0] lo, hi;
    logic [TermsW-1:0] terms;
    int ph;
    for (ph = 0; ph < Phases; ph++) begin
      pick_interval(lo, hi);
      terms = TermsW'($urandom_range(0, 31));
      case (ph)
        0: begin
          lo = 32'sd0;
          hi = One;
          terms = 5'd16;
        end
        1: begin
          lo = -One;
          hi = One;
          terms = 5'd8;
        end
        2: begin
          lo = ValMin;
          hi = ValMax;
          terms = 5'd31;
        end
        3: begin
          if (lo == ValMax) lo = lo - 1;
          hi = lo + 1;
          terms = 5'd1;
        end
        4: terms = 5'd0;
        5: terms = 5'd17;
        default: ;
      endcase
      set_config(lo, hi, terms);
      tx_steady = (ph == 1 || ph == 5);
      rx_steady = (ph == 1 || ph == 6);
      repeat (PhaseItems) offer_item(rand_item());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Hold off the result side while items keep coming, so the input stalls
  task automatic test_result_backpressure();
    set_config(-One, One, 5'd16);
    hold_cycles = HoldCycles;
    tx_steady = 1'b1;
    repeat (12) offer_item(eval_item(rand_x()));
    tx_steady = 1'b0;
    wait_drained();
  endtask

  // Result side: random stalls landing while valid is up, none when rx_steady, and a hold of hold_cycles when set
  initial begin : result_sink
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_if.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end
      stall = rx_steady ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_if.ready = 1'b0;
        do @(posedge clk_i); while (out_if.valid !== 1'b1);
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
    end
  end

  // Compare each accepted result with the oldest pending evaluation
  always @(posedge clk_i) begin : result_check
    series_res_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_series.size() == 0) begin
        $error("series_value: expected no result, actual %h", out_if.series_value);
        err_count++;
      end else begin
        want = expected_series.pop_front();
        if (out_if.series_value !== want.series_value) begin
          $error("series_value: expected %h, actual %h", want.series_value,
                 out_if.series_value);
          err_count++;
        end
        if (out_if.range_error !== want.range_error) begin
          $error("range_error: expected %b, actual %b", want.range_error,
                 out_if.range_error);
          err_count++;
        end
        if (out_if.saturated !== want.saturated) begin
          $error("saturated: expected %b, actual %b", want.saturated, out_if.saturated);
          err_count++;
        end
        if (want.range_error) n_range_errs++;
        if (want.saturated) n_clipped++;
      end
    end
  end

  initial begin : run_tests
    in_if.valid = 1'b0;
    in_if.operation = OpLoad;
    in_if.coef_index = '0;
    in_if.coef_value = '0;
    in_if.x_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_corner_settings();
    test_random_settings();
    test_result_backpressure();
    wait_drained();

    $display("Run covered %0d coefficient loads and %0d evaluations over %0d settings.",
             n_loads, n_evals, n_settings);
    $display("Of the results, %0d were out of range and %0d were clipped.",
             n_range_errs, n_clipped);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
